// ----- sv/tamh_pkg.sv -----
// Shared types, constants and register codes for the touch affine mapper.
`default_nettype none

package tamh_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W   = 12;
   localparam int COEF_W     = 32;
   localparam int THR_W      = 12;
   localparam int PIX_W      = 16;
   localparam int CSR_NUM    = 8;
   localparam int CSR_IDX_W  = $clog2(CSR_NUM);
   localparam int CSR_DATA_W = 32;

   // Default parameter values
   localparam int RAW_BITS_DEFAULT  = 12;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Reset values of the configuration registers
   localparam logic signed [COEF_W-1:0] COEF_ONE        = 32'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_ZERO       = 32'sd0;
   localparam logic [THR_W-1:0]         PRESS_DEFAULT   = 12'd400;
   localparam logic [THR_W-1:0]         RELEASE_DEFAULT = 12'd250;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_XX     = 3'd0,
      CSR_COEF_XY     = 3'd1,
      CSR_OFFSET_X    = 3'd2,
      CSR_COEF_YX     = 3'd3,
      CSR_COEF_YY     = 3'd4,
      CSR_OFFSET_Y    = 3'd5,
      CSR_PRESS_THR   = 3'd6,
      CSR_RELEASE_THR = 3'd7
   } csr_index_type;

   // Event codes
   typedef enum logic [1:0] {
      EV_DOWN = 2'd0,
      EV_MOVE = 2'd1,
      EV_UP   = 2'd2
   } event_kind_type;

   // Calibration set handed from the register file to the datapath
   typedef struct packed {
      logic signed [COEF_W-1:0] coef_xx;
      logic signed [COEF_W-1:0] coef_xy;
      logic signed [COEF_W-1:0] offset_x;
      logic signed [COEF_W-1:0] coef_yx;
      logic signed [COEF_W-1:0] coef_yy;
      logic signed [COEF_W-1:0] offset_y;
      logic [THR_W-1:0]         press_thr;
      logic [THR_W-1:0]         release_thr;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/touch_affine_map_with_hysteresis.sv -----
// Top level: sample register, affine map and touch state, event output register.
// A sample waits in the input register, then its events load the event register.
// Throughput: one sample per cycle while the event register is free; a sample
// giving two events holds the event register until both are taken, one per cycle.
// Reset: synchronous; clears both stages and the touch flag and loads the
// identity calibration with thresholds 400 and 250.
`default_nettype none

module touch_affine_map_with_hysteresis
   import tamh_pkg::*;
#(
   parameter int RAW_BITS  = RAW_BITS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // sample channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [SAMPLE_W-1:0]     req_raw_x,
   input  wire logic [SAMPLE_W-1:0]     req_raw_y,
   input  wire logic [SAMPLE_W-1:0]     req_pressure,
   // event channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_event_kind,
   output logic signed [PIX_W-1:0]      rsp_screen_x,
   output logic signed [PIX_W-1:0]      rsp_screen_y,
   output logic                         rsp_last,
   // configuration port
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Only the low bits of a reading take part, at most the field width
   localparam int RAW_W = (RAW_BITS < SAMPLE_W) ? RAW_BITS : SAMPLE_W;

   cfg_type cfg;

   logic                   s1_valid_ff, s1_valid_in;
   logic [RAW_W-1:0]       s1_raw_x_ff, s1_raw_x_in;
   logic [RAW_W-1:0]       s1_raw_y_ff, s1_raw_y_in;
   logic [SAMPLE_W-1:0]    s1_pressure_ff, s1_pressure_in;
   logic                   touching_ff, touching_in;

   logic                   out_valid_ff, out_valid_in;
   event_kind_type         out_kind_ff, out_kind_in;
   logic                   out_second_ff, out_second_in;
   logic signed [PIX_W-1:0] out_sx_ff, out_sx_in;
   logic signed [PIX_W-1:0] out_sy_ff, out_sy_in;

   logic                   req_accept;
   logic                   rsp_accept;
   logic                   out_free;
   logic                   s1_adv;
   logic                   out_load;
   logic                   pressed;
   logic                   released;
   logic                   has_event;
   logic                   has_second;
   event_kind_type         first_kind;
   event_kind_type         next_kind;
   logic signed [PIX_W-1:0] map_x;
   logic signed [PIX_W-1:0] map_y;

   tamh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tamh_axis #(.RAW_W(RAW_W), .FRAC_BITS(FRAC_BITS)) u_axis_x (
      .coef_a (cfg.coef_xx),
      .coef_b (cfg.coef_xy),
      .offset (cfg.offset_x),
      .raw_a  (s1_raw_x_ff),
      .raw_b  (s1_raw_y_ff),
      .pixel  (map_x)
   );

   tamh_axis #(.RAW_W(RAW_W), .FRAC_BITS(FRAC_BITS)) u_axis_y (
      .coef_a (cfg.coef_yx),
      .coef_b (cfg.coef_yy),
      .offset (cfg.offset_y),
      .raw_a  (s1_raw_x_ff),
      .raw_b  (s1_raw_y_ff),
      .pixel  (map_y)
   );

   // Hysteresis decision for the sample in the input register
   assign pressed    = s1_pressure_ff > cfg.press_thr;
   assign released   = s1_pressure_ff < cfg.release_thr;
   assign has_event  = touching_ff | pressed;
   assign has_second = touching_ff ? released : 1'b1;
   assign first_kind = touching_ff ? EV_MOVE : EV_DOWN;

   // Handshakes and stage advance
   assign rsp_accept = out_valid_ff & rsp_ready;
   assign out_free   = ~out_valid_ff | (rsp_ready & ~out_second_ff);
   assign s1_adv     = s1_valid_ff & (out_free | ~has_event);
   assign out_load   = s1_adv & has_event;
   assign req_ready  = ~s1_valid_ff | s1_adv;
   assign req_accept = req_valid & req_ready;

   // Follow-on event of a two-event sample
   always_comb begin
      unique case (out_kind_ff)
         EV_DOWN: next_kind = EV_MOVE;
         EV_MOVE: next_kind = EV_UP;
         default: next_kind = EV_UP;
      endcase
   end

   // Input register: capture a sample, drop it once it moves on
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_raw_x_in    = s1_raw_x_ff;
      s1_raw_y_in    = s1_raw_y_ff;
      s1_pressure_in = s1_pressure_ff;
      if (req_accept) begin
         s1_valid_in    = 1'b1;
         s1_raw_x_in    = req_raw_x[RAW_W-1:0];
         s1_raw_y_in    = req_raw_y[RAW_W-1:0];
         s1_pressure_in = req_pressure;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Touch flag: set on press while idle, clear on release while touching
   always_comb begin
      touching_in = touching_ff;
      if (s1_adv) begin
         touching_in = touching_ff ? ~released : pressed;
      end
   end

   // Event register: load a sample's events, advance on each transaction
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_second_in = out_second_ff;
      out_sx_in     = out_sx_ff;
      out_sy_in     = out_sy_ff;
      if (out_load) begin
         out_valid_in  = 1'b1;
         out_kind_in   = first_kind;
         out_second_in = has_second;
         out_sx_in     = map_x;
         out_sy_in     = map_y;
      end else if (rsp_accept) begin
         if (out_second_ff) begin
            out_kind_in   = next_kind;
            out_second_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         touching_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_second_ff <= 1'b0;
         out_kind_ff   <= EV_DOWN;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         touching_ff   <= touching_in;
         out_valid_ff  <= out_valid_in;
         out_second_ff <= out_second_in;
         out_kind_ff   <= out_kind_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      s1_raw_x_ff    <= s1_raw_x_in;
      s1_raw_y_ff    <= s1_raw_y_in;
      s1_pressure_ff <= s1_pressure_in;
      out_sx_ff      <= out_sx_in;
      out_sy_ff      <= out_sy_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_screen_x   = out_sx_ff;
   assign rsp_screen_y   = out_sy_ff;
   assign rsp_last       = ~out_second_ff;

endmodule

`default_nettype wire

// ----- sv/tamh_csr.sv -----
// Configuration register file: affine coefficients and pressure thresholds.
`default_nettype none

module tamh_csr
   import tamh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_XX:     cfg_in.coef_xx     = csr_wdata;
            CSR_COEF_XY:     cfg_in.coef_xy     = csr_wdata;
            CSR_OFFSET_X:    cfg_in.offset_x    = csr_wdata;
            CSR_COEF_YX:     cfg_in.coef_yx     = csr_wdata;
            CSR_COEF_YY:     cfg_in.coef_yy     = csr_wdata;
            CSR_OFFSET_Y:    cfg_in.offset_y    = csr_wdata;
            CSR_PRESS_THR:   cfg_in.press_thr   = csr_wdata[THR_W-1:0];
            CSR_RELEASE_THR: cfg_in.release_thr = csr_wdata[THR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load identity calibration on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_xx     <= COEF_ONE;
         cfg_ff.coef_xy     <= COEF_ZERO;
         cfg_ff.offset_x    <= COEF_ZERO;
         cfg_ff.coef_yx     <= COEF_ZERO;
         cfg_ff.coef_yy     <= COEF_ONE;
         cfg_ff.offset_y    <= COEF_ZERO;
         cfg_ff.press_thr   <= PRESS_DEFAULT;
         cfg_ff.release_thr <= RELEASE_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- sv/tamh_axis.sv -----
// One axis of the affine map: two products, offset, truncate toward zero, saturate.
`default_nettype none

module tamh_axis
   import tamh_pkg::*;
#(
   parameter int RAW_W     = RAW_BITS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic signed [COEF_W-1:0] coef_a,
   input  wire logic signed [COEF_W-1:0] coef_b,
   input  wire logic signed [COEF_W-1:0] offset,
   input  wire logic [RAW_W-1:0]         raw_a,
   input  wire logic [RAW_W-1:0]         raw_b,
   output logic signed [PIX_W-1:0]       pixel
);

   localparam int PROD_W = COEF_W + RAW_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [ACC_W-1:0] PIX_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] PIX_MIN = -ACC_W'(32768);

   logic signed [RAW_W:0]   raw_a_s;
   logic signed [RAW_W:0]   raw_b_s;
   logic signed [PROD_W-1:0] prod_a;
   logic signed [PROD_W-1:0] prod_b;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_biased;
   logic signed [ACC_W-1:0]  whole;

   // Raw readings are unsigned: add a zero sign bit
   assign raw_a_s = signed'({1'b0, raw_a});
   assign raw_b_s = signed'({1'b0, raw_b});

   // Exact weighted sum
   assign prod_a = coef_a * raw_a_s;
   assign prod_b = coef_b * raw_b_s;
   assign acc    = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(offset);

   // Shift out the fraction, rounding negative values up toward zero
   assign acc_biased = acc[ACC_W-1] ? (acc + BIAS) : acc;
   assign whole      = acc_biased >>> FRAC_BITS;

   // Clamp to the pixel range
   always_comb begin
      if (whole > PIX_MAX) begin
         pixel = PIX_MAX[PIX_W-1:0];
      end else if (whole < PIX_MIN) begin
         pixel = PIX_MIN[PIX_W-1:0];
      end else begin
         pixel = whole[PIX_W-1:0];
      end
   end

endmodule

`default_nettype wire
